[rtl/wsts_pkg.sv]
package wsts_pkg;

	localparam int MAX_SERVERS = 16;
	localparam int SRV_BITS    = $clog2(MAX_SERVERS);
	localparam int CNT_BITS    = $clog2(MAX_SERVERS + 1);
	localparam int TIME_BITS   = 48;
	localparam int WEIGHT_BITS = 16;
	localparam int DUR_BITS    = 16;
	localparam int START_BITS  = 48;
	localparam int MODE_BITS   = 2;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	// item kinds carried in tuser
	localparam logic [MODE_BITS-1:0] MODE_LOAD    = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_TASK    = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_RESTART = 2'd2;

	// register map
	localparam int                   ADDR_BITS     = 3;
	localparam logic                 REG_NUM_SERVERS = 1'b0;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage

[rtl/weighted_server_task_scheduler_top.sv]
// Load and restart items are accepted in ST_IDLE and complete there; a task item holds
// the input until its result is committed, with extra scans for the earliest finish time
// and a re-free pass when all servers are busy, and its commit may also wait on m_tready.
// The scans use one shared 48-bit comparator that visits one server per cycle.
// Asynchronous active-low reset clears time, task count, busy marks, finish
// times and the output; num_servers resets to 16; weights are not reset.
module weighted_server_task_scheduler_top
	import wsts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [39:0]          s_tdata,  // server_index[3:0], server_weight[19:4],
	                                       // task_duration[35:20], zero pad
	input  logic [MODE_BITS-1:0] s_tuser,  // mode
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [55:0]          m_tdata   // assigned_server[3:0], start_time[51:4], zero pad
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_FREE,
		ST_MINS,
		ST_JUMP,
		ST_REFREE,
		ST_PICK,
		ST_COMMIT
	} state_t;

	state_t                 state_q;
	logic [CNT_BITS-1:0]    num_servers_q;
	logic [WEIGHT_BITS-1:0] weight_q [MAX_SERVERS];
	logic [TIME_BITS-1:0]   finish_q [MAX_SERVERS];
	logic [MAX_SERVERS-1:0] busy_q;
	logic [TIME_BITS-1:0]   cur_time_q;
	logic [TIME_BITS-1:0]   task_cnt_q;
	logic [TIME_BITS-1:0]   earliest_q;
	logic [DUR_BITS-1:0]    dur_q;
	logic [SRV_BITS-1:0]    idx_q;
	logic [SRV_BITS-1:0]    last_q;
	logic [SRV_BITS-1:0]    best_q;
	logic                   found_q;
	logic                   any_free_q;
	logic                   m_valid_q;
	logic [SRV_BITS-1:0]    out_srv_q;
	logic [START_BITS-1:0]  out_time_q;

	logic                   in_xfer;
	logic                   cfg_wr;
	logic [SRV_BITS-1:0]    in_srv;
	logic [WEIGHT_BITS-1:0] in_weight;
	logic [DUR_BITS-1:0]    in_dur;
	logic [TIME_BITS-1:0]   opa;
	logic [TIME_BITS-1:0]   opb;
	cmp_res_t               cmp;
	logic                   le;
	logic                   at_last;
	logic                   out_free;
	logic [SRV_BITS-1:0]    last_idx;
	logic [TIME_BITS:0]     sum;
	logic [TIME_BITS-1:0]   finish_new;

	assign in_srv    = s_tdata[3:0];
	assign in_weight = s_tdata[19:4];
	assign in_dur    = s_tdata[35:20];

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NUM_SERVERS);
	assign prdata = (paddr[2] == REG_NUM_SERVERS)
		? {{(32-CNT_BITS){1'b0}}, num_servers_q} : 32'd0;

	// active count clamped to 1..MAX_SERVERS, kept as last index
	always_comb begin
		if (num_servers_q == '0) begin
			last_idx = '0;
		end else if (num_servers_q > CNT_BITS'(MAX_SERVERS)) begin
			last_idx = SRV_BITS'(MAX_SERVERS - 1);
		end else begin
			last_idx = SRV_BITS'(num_servers_q - 1'b1);
		end
	end

	// operand select for the shared comparator
	always_comb begin
		opa = finish_q[idx_q];
		opb = cur_time_q;
		case (state_q)
			ST_INIT: begin
				opa = cur_time_q;
				opb = task_cnt_q;
			end
			ST_MINS: begin
				opb = earliest_q;
			end
			ST_JUMP: begin
				opa = cur_time_q;
				opb = earliest_q;
			end
			ST_PICK: begin
				opa = {{(TIME_BITS-WEIGHT_BITS){1'b0}}, weight_q[idx_q]};
				opb = {{(TIME_BITS-WEIGHT_BITS){1'b0}}, weight_q[best_q]};
			end
			default: begin
			end
		endcase
	end

	wsts_cmp u_cmp (
		.a   (opa),
		.b   (opb),
		.res (cmp)
	);

	assign le       = cmp.lt || cmp.eq;
	assign at_last  = (idx_q == last_q);
	assign out_free = !m_valid_q || m_tready;

	assign sum        = {1'b0, cur_time_q} + {{(TIME_BITS+1-DUR_BITS){1'b0}}, dur_q};
	assign finish_new = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];

	// weight store, no reset
	always_ff @(posedge clk) begin
		if (in_xfer && s_tuser == MODE_LOAD) begin
			weight_q[in_srv] <= in_weight;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			num_servers_q <= CNT_BITS'(MAX_SERVERS);
			for (int i = 0; i < MAX_SERVERS; i++) begin
				finish_q[i] <= '0;
			end
			busy_q     <= '0;
			cur_time_q <= '0;
			task_cnt_q <= '0;
			earliest_q <= '0;
			dur_q      <= '0;
			idx_q      <= '0;
			last_q     <= '0;
			best_q     <= '0;
			found_q    <= 1'b0;
			any_free_q <= 1'b0;
			m_valid_q  <= 1'b0;
			out_srv_q  <= '0;
			out_time_q <= '0;
		end else begin
			if (cfg_wr) begin
				num_servers_q <= pwdata[CNT_BITS-1:0];
			end
			if (state_q == ST_COMMIT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (s_tuser == MODE_RESTART) begin
							for (int i = 0; i < MAX_SERVERS; i++) begin
								finish_q[i] <= '0;
							end
							busy_q     <= '0;
							cur_time_q <= '0;
							task_cnt_q <= '0;
						end else if (s_tuser == MODE_TASK) begin
							dur_q   <= in_dur;
							last_q  <= last_idx;
							state_q <= ST_INIT;
						end
					end
				end
				ST_INIT: begin
					if (cmp.lt) begin
						cur_time_q <= task_cnt_q;
					end
					idx_q      <= '0;
					any_free_q <= 1'b0;
					state_q    <= ST_FREE;
				end
				ST_FREE: begin
					if (busy_q[idx_q] && le) begin
						busy_q[idx_q] <= 1'b0;
					end
					if (at_last) begin
						idx_q <= '0;
						if (any_free_q || !busy_q[idx_q] || le) begin
							found_q <= 1'b0;
							state_q <= ST_PICK;
						end else begin
							earliest_q <= TIME_MAX;
							state_q    <= ST_MINS;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
						if (!busy_q[idx_q] || le) begin
							any_free_q <= 1'b1;
						end
					end
				end
				ST_MINS: begin
					if (cmp.lt) begin
						earliest_q <= finish_q[idx_q];
					end
					idx_q <= idx_q + 1'b1;
					if (at_last) begin
						state_q <= ST_JUMP;
					end
				end
				ST_JUMP: begin
					if (cmp.lt) begin
						cur_time_q <= earliest_q;
					end
					idx_q   <= '0;
					state_q <= ST_REFREE;
				end
				ST_REFREE: begin
					if (le) begin
						busy_q[idx_q] <= 1'b0;
					end
					if (at_last) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= ST_PICK;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_PICK: begin
					if (!busy_q[idx_q] && (!found_q || cmp.lt)) begin
						best_q  <= idx_q;
						found_q <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					if (at_last) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (out_free) begin
						busy_q[best_q]   <= 1'b1;
						finish_q[best_q] <= finish_new;
						out_srv_q        <= best_q;
						out_time_q       <= cur_time_q[START_BITS-1:0];
						if (task_cnt_q != TIME_MAX) begin
							task_cnt_q <= task_cnt_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(56-START_BITS-SRV_BITS){1'b0}}, out_time_q, out_srv_q};

endmodule

[rtl/wsts_cmp.sv]
module wsts_cmp
	import wsts_pkg::*;
(
	input  logic [TIME_BITS-1:0] a,
	input  logic [TIME_BITS-1:0] b,
	output cmp_res_t             res
);

	always_comb begin
		res.lt = (a < b);
		res.eq = (a == b);
	end

endmodule
